@@ rtl/rmag_pkg.sv @@
// ---------------------------------------------------------------------------
// rmag_pkg: shared types and constants
// Window geometry, request and status codes, and the controller states.
// ---------------------------------------------------------------------------
`default_nettype none
package rmag_pkg;
	localparam int WINDOWS       = 4;
	localparam int WIN_BYTES     = 4096;
	localparam int WIN_WORDS     = (WIN_BYTES + 3) / 4;
	localparam int MEM_WORDS     = WINDOWS * WIN_WORDS;
	localparam int MEM_AW        = $clog2(MEM_WORDS);
	localparam int WIN_OW        = $clog2(WIN_WORDS);
	localparam int ALLOC_ENTRIES = 16;
	localparam int TBL_AW        = $clog2(ALLOC_ENTRIES);
	localparam int CNT_W         = TBL_AW + 1;

	localparam logic [2:0] REQ_RD_BYTE = 3'd0;
	localparam logic [2:0] REQ_RD_WORD = 3'd1;
	localparam logic [2:0] REQ_WR_BYTE = 3'd2;
	localparam logic [2:0] REQ_WR_WORD = 3'd3;
	localparam logic [2:0] REQ_ALLOC   = 3'd4;
	localparam logic [2:0] REQ_CLEAR   = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_MISALIGN  = 3'd1;
	localparam logic [2:0] ST_NOT_ALLOC = 3'd2;
	localparam logic [2:0] ST_NO_WINDOW = 3'd3;
	localparam logic [2:0] ST_OVERLAP   = 3'd4;
	localparam logic [2:0] ST_BEYOND    = 3'd5;
	localparam logic [2:0] ST_FULL      = 3'd6;

	localparam logic [2:0] CFG_LOCK  = 3'd0;
	localparam logic [2:0] CFG_WIN0  = 3'd1;
	localparam logic [2:0] CFG_WIN3  = 3'd4;
	localparam logic [2:0] CFG_DWIN  = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE, S_CLR, S_DEC, S_RD, S_SCAN, S_ALF
	} state_t;

	typedef logic [WINDOWS-1:0][31:0] bases_t;

	// lowest window holding a; bit 2 is the hit flag
	function automatic logic [2:0] find_win(logic [31:0] a, bases_t b);
		logic [2:0] r;
		logic [31:0] d;
		r = 3'd0;
		for (int w = WINDOWS - 1; w >= 0; w--) begin
			d = a - b[w];
			if (a >= b[w] && {1'b0, d} < 33'(WIN_BYTES))
				r = {1'b1, 2'(w)};
		end
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/rmag_ram.sv @@
// ---------------------------------------------------------------------------
// rmag_ram: generic single-port RAM
// One access per cycle, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module rmag_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

@@ rtl/region_memory_with_alloc_guard.sv @@
// ---------------------------------------------------------------------------
// region_memory_with_alloc_guard: windowed memory with allocation guard
// Byte/word little-endian memory over four windows, with an allocation
// table, lock checking, bump allocation and a clear request.
// ---------------------------------------------------------------------------
// Usage:
//  - Request words enter on in_valid/in_stall; one result word leaves on
//    out_valid/out_stall for every request.
//  - One request is worked on at a time. Word writes, unknown codes and
//    decode errors finish in decode; a passing explicit allocate adds
//    the allocate step. Reads and byte writes: decode, memory read, finish
//    (the byte write is a read-modify-write on the single RAM port).
//  - Automatic allocate walks the table one entry a cycle.
//  - Clear sweeps the word memory one word a cycle.
//  - After reset the same clearing pass runs, with in_stall high
//    throughout. Configuration writes are taken at any time.
//  - The result sits in an output register; while the receiver stalls,
//    the next request waits in_stall until the register is freed.
//  - The table lives in flops (all entries compared at once); only
//    entries below the count are ever looked at.
// ---------------------------------------------------------------------------
`default_nettype none
module region_memory_with_alloc_guard (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [31:0] address,
	input  wire logic [31:0] write_data,
	input  wire logic [12:0] alloc_size,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] read_data,
	output logic      [31:0] alloc_start,
	output logic      [2:0]  status,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	// configuration
	logic                 lock_q;
	rmag_pkg::bases_t     wb_q;
	logic [1:0]           dwin_q;

	// request held for the duration of the work
	rmag_pkg::state_t     state_q, state_d;
	logic [2:0]           req_q;
	logic [31:0]          addr_q;
	logic [31:0]          wd_q;
	logic [12:0]          size_q;
	logic [rmag_pkg::MEM_AW-1:0] idx_q;
	logic [31:0]          base_q;
	logic [31:0]          start_q;
	logic [rmag_pkg::TBL_AW-1:0] scan_q;
	logic [rmag_pkg::MEM_AW:0]   clr_q;
	logic                 clr_req_q;

	// allocation table and count
	logic [31:0]          tbl_start_q [rmag_pkg::ALLOC_ENTRIES];
	logic [12:0]          tbl_size_q  [rmag_pkg::ALLOC_ENTRIES];
	logic [rmag_pkg::CNT_W-1:0] cnt_q;

	// result register
	logic                 ov_q;
	logic [31:0]          rd_q, as_q;
	logic [2:0]           st_q;

	// RAM port
	logic                 ram_we;
	logic [rmag_pkg::MEM_AW-1:0] ram_addr;
	logic [31:0]          ram_wdata, ram_rdata;

	rmag_ram #(.WIDTH(32), .DEPTH(rmag_pkg::MEM_WORDS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	logic accept;
	assign in_stall  = (state_q != rmag_pkg::S_IDLE) || ov_q;
	assign accept    = in_valid && !in_stall;
	assign out_valid = ov_q;
	assign read_data = rd_q;
	assign alloc_start = as_q;
	assign status    = st_q;

	// decode-stage lookups on the held address
	logic        hit_any;
	logic [2:0]  win;
	logic [31:0] off;
	logic        misal;
	always_comb begin
		hit_any = 1'b0;
		for (int i = 0; i < rmag_pkg::ALLOC_ENTRIES; i++)
			if (rmag_pkg::CNT_W'(i) < cnt_q && addr_q >= tbl_start_q[i]
			    && {1'b0, addr_q} < {1'b0, tbl_start_q[i]} + 33'(tbl_size_q[i]))
				hit_any = 1'b1;
		win   = rmag_pkg::find_win(addr_q, wb_q);
		off   = addr_q - wb_q[win[1:0]];
		misal = req_q[0] && (addr_q[1:0] != 2'b00);
	end

	// scan step: entry end counts when its window shares the data base
	logic [2:0]  ewin;
	logic [31:0] eend;
	logic        ebump;
	always_comb begin
		ewin  = rmag_pkg::find_win(tbl_start_q[scan_q], wb_q);
		eend  = tbl_start_q[scan_q] + 32'(tbl_size_q[scan_q]);
		ebump = ewin[2] && (wb_q[ewin[1:0]] == base_q) && (eend > start_q);
	end

	logic        last_scan;
	logic        beyond;
	assign last_scan = (rmag_pkg::CNT_W'(scan_q) + 1'b1) >= cnt_q;
	assign beyond    = {1'b0, start_q - base_q} + 33'(size_q)
	                   > 33'(rmag_pkg::WIN_BYTES);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rmag_pkg::S_IDLE:
				if (accept) state_d = rmag_pkg::S_DEC;
			rmag_pkg::S_CLR:
				if (clr_q[rmag_pkg::MEM_AW]) state_d = rmag_pkg::S_IDLE;
			rmag_pkg::S_DEC: begin
				case (req_q)
					rmag_pkg::REQ_RD_BYTE, rmag_pkg::REQ_RD_WORD,
					rmag_pkg::REQ_WR_BYTE:
						if (!misal && !(lock_q && !hit_any) && win[2])
							state_d = rmag_pkg::S_RD;
						else
							state_d = rmag_pkg::S_IDLE;
					rmag_pkg::REQ_ALLOC:
						if (addr_q != 32'd0)
							state_d = (!hit_any && win[2]) ? rmag_pkg::S_ALF
							                               : rmag_pkg::S_IDLE;
						else
							state_d = (cnt_q == '0) ? rmag_pkg::S_ALF
							                        : rmag_pkg::S_SCAN;
					rmag_pkg::REQ_CLEAR: state_d = rmag_pkg::S_CLR;
					default:             state_d = rmag_pkg::S_IDLE;
				endcase
			end
			rmag_pkg::S_RD:   state_d = rmag_pkg::S_IDLE;
			rmag_pkg::S_SCAN: if (last_scan) state_d = rmag_pkg::S_ALF;
			rmag_pkg::S_ALF:  state_d = rmag_pkg::S_IDLE;
			default:          state_d = rmag_pkg::S_IDLE;
		endcase
	end

	// actions
	logic        fin;
	logic [31:0] fin_rd, fin_as;
	logic [2:0]  fin_st;
	logic        tbl_we;
	logic [4:0]  lsh;
	logic [7:0]  rbyte;
	logic [31:0] merged;
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = idx_q;
		ram_wdata = wd_q;
		fin       = 1'b0;
		fin_rd    = '0;
		fin_as    = '0;
		fin_st    = rmag_pkg::ST_OK;
		tbl_we    = 1'b0;
		// byte lane follows the offset within the window
		lsh       = {off[1:0], 3'b000};
		rbyte     = ram_rdata[lsh +: 8];
		merged    = ram_rdata;
		merged[lsh +: 8] = wd_q[7:0];
		case (state_q)
			rmag_pkg::S_CLR: begin
				ram_we    = !clr_q[rmag_pkg::MEM_AW];
				ram_addr  = clr_q[rmag_pkg::MEM_AW-1:0];
				ram_wdata = '0;
				fin       = clr_q[rmag_pkg::MEM_AW] && clr_req_q;
			end
			rmag_pkg::S_DEC: begin
				ram_addr = {win[1:0], off[rmag_pkg::WIN_OW+1:2]};
				case (req_q)
					rmag_pkg::REQ_RD_BYTE, rmag_pkg::REQ_RD_WORD,
					rmag_pkg::REQ_WR_BYTE, rmag_pkg::REQ_WR_WORD: begin
						if (misal) begin
							fin = 1'b1; fin_st = rmag_pkg::ST_MISALIGN;
						end else if (lock_q && !hit_any) begin
							fin = 1'b1; fin_st = rmag_pkg::ST_NOT_ALLOC;
						end else if (!win[2]) begin
							fin = 1'b1; fin_st = rmag_pkg::ST_NO_WINDOW;
						end else if (req_q == rmag_pkg::REQ_WR_WORD) begin
							fin    = 1'b1;
							ram_we = 1'b1;
						end
					end
					rmag_pkg::REQ_ALLOC:
						if (addr_q != 32'd0) begin
							if (hit_any) begin
								fin = 1'b1; fin_st = rmag_pkg::ST_OVERLAP;
							end else if (!win[2]) begin
								fin = 1'b1; fin_st = rmag_pkg::ST_NO_WINDOW;
							end
						end
					rmag_pkg::REQ_CLEAR: ;
					default: fin = 1'b1;
				endcase
			end
			rmag_pkg::S_RD: begin
				fin = 1'b1;
				case (req_q)
					rmag_pkg::REQ_RD_BYTE: fin_rd = {24'd0, rbyte};
					rmag_pkg::REQ_RD_WORD: fin_rd = ram_rdata;
					default: begin
						ram_we    = 1'b1;
						ram_wdata = merged;
					end
				endcase
			end
			rmag_pkg::S_ALF: begin
				fin = 1'b1;
				if (beyond)
					fin_st = rmag_pkg::ST_BEYOND;
				else if (cnt_q >= rmag_pkg::CNT_W'(rmag_pkg::ALLOC_ENTRIES))
					fin_st = rmag_pkg::ST_FULL;
				else begin
					tbl_we = 1'b1;
					fin_as = start_q;
				end
			end
			default: ;
		endcase
	end

	// table write port
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_start_q[cnt_q[rmag_pkg::TBL_AW-1:0]] <= start_q;
			tbl_size_q[cnt_q[rmag_pkg::TBL_AW-1:0]]  <= size_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			addr_q <= address;
			wd_q   <= write_data;
			size_q <= alloc_size;
		end
		if (state_q == rmag_pkg::S_DEC) begin
			idx_q   <= {win[1:0], off[rmag_pkg::WIN_OW+1:2]};
			scan_q  <= '0;
			if (addr_q != 32'd0) begin
				base_q  <= wb_q[win[1:0]];
				start_q <= addr_q;
			end else begin
				base_q  <= wb_q[dwin_q];
				start_q <= wb_q[dwin_q];
			end
		end
		if (state_q == rmag_pkg::S_SCAN) begin
			scan_q <= scan_q + 1'b1;
			if (ebump) start_q <= eend;
		end
		if (fin) begin
			rd_q <= fin_rd;
			as_q <= fin_as;
			st_q <= fin_st;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rmag_pkg::S_CLR;
			clr_q     <= '0;
			clr_req_q <= 1'b0;
			cnt_q     <= '0;
			ov_q      <= 1'b0;
			lock_q    <= 1'b0;
			wb_q[0]   <= 32'h0040_0000;
			wb_q[1]   <= 32'h1000_0000;
			wb_q[2]   <= 32'h7FFF_F000;
			wb_q[3]   <= 32'h8000_0000;
			dwin_q    <= 2'd1;
		end else begin
			state_q <= state_d;
			if (state_q == rmag_pkg::S_CLR && !clr_q[rmag_pkg::MEM_AW])
				clr_q <= clr_q + 1'b1;
			if (state_q == rmag_pkg::S_DEC && req_q == rmag_pkg::REQ_CLEAR) begin
				clr_q     <= '0;
				clr_req_q <= 1'b1;
				cnt_q     <= '0;
			end
			if (state_q == rmag_pkg::S_CLR && clr_q[rmag_pkg::MEM_AW])
				clr_req_q <= 1'b0;
			if (tbl_we)
				cnt_q <= cnt_q + 1'b1;
			if (fin)
				ov_q <= 1'b1;
			else if (ov_q && !out_stall)
				ov_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					rmag_pkg::CFG_LOCK: lock_q <= cfg_data[0];
					rmag_pkg::CFG_DWIN: dwin_q <= cfg_data[1:0];
					default:
						if (cfg_index >= rmag_pkg::CFG_WIN0
						    && cfg_index <= rmag_pkg::CFG_WIN3)
							wb_q[2'(cfg_index - rmag_pkg::CFG_WIN0)] <= cfg_data;
				endcase
			end
		end
	end
endmodule
`default_nettype wire
